// ----- rtl/tnrx_pkg.sv -----
package tnrx_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 16;

  // Telnet command codes
  localparam logic [BYTE_W-1:0] TN_IAC  = 8'd255;
  localparam logic [BYTE_W-1:0] TN_DONT = 8'd254;
  localparam logic [BYTE_W-1:0] TN_DO   = 8'd253;
  localparam logic [BYTE_W-1:0] TN_WONT = 8'd252;
  localparam logic [BYTE_W-1:0] TN_WILL = 8'd251;
  localparam logic [BYTE_W-1:0] TN_SB   = 8'd250;
  localparam logic [BYTE_W-1:0] TN_SE   = 8'd240;
  localparam logic [BYTE_W-1:0] TN_WINSIZE = 8'd31;

  // Default window size when the stored size is zero
  localparam logic [SIZE_W-1:0] DEF_COLS = 16'd80;
  localparam logic [SIZE_W-1:0] DEF_ROWS = 16'd24;

  // Input item kinds
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_RESIZE  = 1'b1;

  // Output destinations
  localparam logic DEST_TERM = 1'b0;
  localparam logic DEST_NET  = 1'b1;

endpackage

// ----- rtl/tnrx_if.sv -----
interface tnrx_in_if;
  import tnrx_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  logic [SIZE_W-1:0] new_cols;
  logic [SIZE_W-1:0] new_rows;

  modport source (output valid, output op, output rx_byte, output new_cols,
                  output new_rows, input ready);
  modport sink   (input valid, input op, input rx_byte, input new_cols,
                  input new_rows, output ready);
endinterface

interface tnrx_out_if;
  import tnrx_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_dest;
  logic              last;

  modport source (output valid, output out_byte, output out_dest, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_dest, input last,
                  output ready);
endinterface

// ----- rtl/telnet_rx_option_negotiator_core.sv -----
// Channel  | Dir | Payload                              | Handshake
// ---------+-----+--------------------------------------+------------------
// in_ch    | in  | op, rx_byte, new_cols, new_rows      | valid / ready
// out_ch   | out | out_byte, out_dest, last             | valid / ready
//
// One item enters per cycle while each item yields at most one byte and
// out_ch does not stall. A reply goes out one byte at a time: a DO/WILL answer
// is 3 bytes, a window-size report 9 to 13 bytes, and the input stalls until
// the single byte sequencer that walks one reply job has sent its last byte. Reset is
// synchronous, active low, and returns the parser to plain data with window
// reporting off.
// A stall on out_ch holds the output register and the job; the input side
// keeps taking items as long as the job slot is free or frees this cycle.
module telnet_rx_option_negotiator_core (
  input  logic             clk,
  input  logic             rst_n,
  tnrx_in_if.sink          in_ch,
  tnrx_out_if.source       out_ch
);
  import tnrx_pkg::*;

  // Parser phase
  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_IAC,
    PH_OPT,
    PH_SB,
    PH_SB_IAC
  } phase_t;

  // Kind of reply job handed to the byte sequencer
  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_REPLY,
    JOB_NAWS
  } job_kind_t;

  // Positions within the window-size report: IAC SB 31, four size bytes
  // each followed by an optional escape slot, then IAC SE.
  localparam logic [3:0] POS_D0    = 4'd3;
  localparam logic [3:0] POS_D1    = 4'd5;
  localparam logic [3:0] POS_D2    = 4'd7;
  localparam logic [3:0] POS_D3    = 4'd9;
  localparam logic [3:0] POS_REPLY_LAST = 4'd2;
  localparam logic [3:0] POS_NAWS_LAST  = 4'd12;

  // Parser and window state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_cmd_r, held_cmd_nxt;
  logic              naws_on_r, naws_on_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] rows_r, rows_nxt;

  // Job slot
  logic              job_vld_r;
  job_kind_t         job_kind_r;
  logic [BYTE_W-1:0] job_b0_r;
  logic [BYTE_W-1:0] job_opt_r;
  logic [SIZE_W-1:0] job_w_r;
  logic [SIZE_W-1:0] job_h_r;
  logic [3:0]        job_pos_r;

  // Output register
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_dest_r;
  logic              out_last_r;

  // New job built from the accepted item
  logic              new_job;
  job_kind_t         new_kind;
  logic [BYTE_W-1:0] new_b0;
  logic [BYTE_W-1:0] new_opt;

  // Sequencer outputs
  logic              in_fire;
  logic              emit_fire;
  logic              job_last;
  logic              job_done;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_dest;
  logic [3:0]        pos_nxt;
  logic              skip_esc;
  logic [BYTE_W-1:0] d0, d1, d2, d3;

  // Take a new item when the job slot is empty or drains this cycle.
  assign emit_fire = job_vld_r && (!out_vld_r || out_ch.ready);
  assign job_done  = emit_fire && job_last;
  assign in_ch.ready = !job_vld_r || job_done;
  assign in_fire   = in_ch.valid && in_ch.ready;

  // Parse one item; update state and decide on a reply job.
  always_comb begin
    phase_nxt    = phase_r;
    held_cmd_nxt = held_cmd_r;
    naws_on_nxt  = naws_on_r;
    cols_nxt     = cols_r;
    rows_nxt     = rows_r;
    new_job      = 1'b0;
    new_kind     = JOB_DATA;
    new_b0       = in_ch.rx_byte;
    new_opt      = in_ch.rx_byte;
    if (in_fire) begin
      if (in_ch.op == OP_RESIZE) begin
        // Store the size; report it only when the peer asked for it
        cols_nxt = in_ch.new_cols;
        rows_nxt = in_ch.new_rows;
        new_job  = naws_on_r;
        new_kind = JOB_NAWS;
      end else begin
        unique case (phase_r)
          PH_NORMAL: begin
            if (in_ch.rx_byte == TN_IAC) begin
              phase_nxt = PH_IAC;
            end else begin
              new_job  = 1'b1;
              new_kind = JOB_DATA;
            end
          end
          PH_IAC: begin
            if (in_ch.rx_byte == TN_IAC) begin
              // Escaped 255 goes to the terminal
              new_job   = 1'b1;
              new_kind  = JOB_DATA;
              phase_nxt = PH_NORMAL;
            end else if (in_ch.rx_byte == TN_DO || in_ch.rx_byte == TN_DONT ||
                         in_ch.rx_byte == TN_WILL || in_ch.rx_byte == TN_WONT) begin
              held_cmd_nxt = in_ch.rx_byte;
              phase_nxt    = PH_OPT;
            end else if (in_ch.rx_byte == TN_SB) begin
              phase_nxt = PH_SB;
            end else begin
              // Drop any other command
              phase_nxt = PH_NORMAL;
            end
          end
          PH_OPT: begin
            if (held_cmd_r == TN_DO && in_ch.rx_byte == TN_WINSIZE) begin
              naws_on_nxt = 1'b1;
              new_job     = 1'b1;
              new_kind    = JOB_NAWS;
            end else if (held_cmd_r == TN_DONT && in_ch.rx_byte == TN_WINSIZE) begin
              naws_on_nxt = 1'b0;
            end else if (held_cmd_r == TN_DO) begin
              new_job  = 1'b1;
              new_kind = JOB_REPLY;
              new_b0   = TN_WONT;
            end else if (held_cmd_r == TN_WILL) begin
              new_job  = 1'b1;
              new_kind = JOB_REPLY;
              new_b0   = TN_DONT;
            end
            phase_nxt = PH_NORMAL;
          end
          PH_SB: begin
            if (in_ch.rx_byte == TN_IAC) begin
              phase_nxt = PH_SB_IAC;
            end
          end
          PH_SB_IAC: begin
            phase_nxt = (in_ch.rx_byte == TN_SE) ? PH_NORMAL : PH_SB;
          end
          default: begin
            phase_nxt = PH_NORMAL;
          end
        endcase
      end
    end
  end

  // Size bytes of the job, big-endian
  assign d0 = job_w_r[SIZE_W-1:BYTE_W];
  assign d1 = job_w_r[BYTE_W-1:0];
  assign d2 = job_h_r[SIZE_W-1:BYTE_W];
  assign d3 = job_h_r[BYTE_W-1:0];

  // Skip the escape slot after a size byte that is not 255
  assign skip_esc = (job_pos_r == POS_D0 && d0 != TN_IAC) ||
                    (job_pos_r == POS_D1 && d1 != TN_IAC) ||
                    (job_pos_r == POS_D2 && d2 != TN_IAC) ||
                    (job_pos_r == POS_D3 && d3 != TN_IAC);

  always_comb begin
    emit_byte = job_b0_r;
    emit_dest = DEST_NET;
    job_last  = 1'b0;
    pos_nxt   = job_pos_r + 4'd1;
    case (job_kind_r)
      JOB_DATA: begin
        emit_dest = DEST_TERM;
        job_last  = 1'b1;
      end
      JOB_REPLY: begin
        job_last = (job_pos_r == POS_REPLY_LAST);
        case (job_pos_r)
          4'd0:    emit_byte = TN_IAC;
          4'd1:    emit_byte = job_b0_r;
          default: emit_byte = job_opt_r;
        endcase
      end
      JOB_NAWS: begin
        job_last = (job_pos_r == POS_NAWS_LAST);
        if (skip_esc) begin
          pos_nxt = job_pos_r + 4'd2;
        end
        case (job_pos_r)
          4'd0:    emit_byte = TN_IAC;
          4'd1:    emit_byte = TN_SB;
          4'd2:    emit_byte = TN_WINSIZE;
          4'd3:    emit_byte = d0;
          4'd5:    emit_byte = d1;
          4'd7:    emit_byte = d2;
          4'd9:    emit_byte = d3;
          4'd11:   emit_byte = TN_IAC;
          4'd12:   emit_byte = TN_SE;
          default: emit_byte = TN_IAC;
        endcase
      end
      default: begin
        job_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_NORMAL;
      held_cmd_r <= '0;
      naws_on_r  <= 1'b0;
      cols_r     <= '0;
      rows_r     <= '0;
      job_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      held_cmd_r <= held_cmd_nxt;
      naws_on_r  <= naws_on_nxt;
      cols_r     <= cols_nxt;
      rows_r     <= rows_nxt;

      // Load a new job, retire a finished one, or advance the current one
      if (in_fire && new_job) begin
        job_vld_r  <= 1'b1;
        job_kind_r <= new_kind;
        job_b0_r   <= new_b0;
        job_opt_r  <= new_opt;
        job_w_r    <= (cols_nxt == '0) ? DEF_COLS : cols_nxt;
        job_h_r    <= (rows_nxt == '0) ? DEF_ROWS : rows_nxt;
        job_pos_r  <= '0;
      end else if (job_done) begin
        job_vld_r <= 1'b0;
      end else if (emit_fire) begin
        job_pos_r <= pos_nxt;
      end

      // Output register: load on emit, drop once taken
      if (emit_fire) begin
        out_vld_r  <= 1'b1;
        out_byte_r <= emit_byte;
        out_dest_r <= emit_dest;
        out_last_r <= job_last;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_dest = out_dest_r;
  assign out_ch.last     = out_last_r;

endmodule
